/* rtl/core/tsgc_pkg.sv */
`default_nettype none
package tsgc_pkg;

   localparam longint unsigned STEPS_PER_REVOLUTION = 64'd4194304;

   localparam logic [32:0] REV_STEPS = 33'(STEPS_PER_REVOLUTION);
   localparam logic [32:0] REV_LAST  = 33'(STEPS_PER_REVOLUTION - 64'd1);
   localparam logic [32:0] REV_HALF  = 33'(STEPS_PER_REVOLUTION / 64'd2);

   typedef enum logic [2:0] {
      ACT_SIDEREAL_TICK = 3'd0,
      ACT_MOVE_TICK     = 3'd1,
      ACT_MOVE_REL      = 3'd2,
      ACT_GOTO          = 3'd3,
      ACT_SET_POS       = 3'd4,
      ACT_START_TRACK   = 3'd5,
      ACT_STOP_TRACK    = 3'd6,
      ACT_STOP_MOVE     = 3'd7
   } action_type;

   // clamp a 41-bit sum to the 40-bit signed range of the move count
   function automatic logic [39:0] sat_rem(input logic [40:0] v);
      logic [39:0] r;
      if (v[40] != v[39]) begin
         r = v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
      end else begin
         r = v[39:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/tsgc_if.sv */
`default_nettype none
interface tsgc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] amount;
   logic        flag;

   modport source (output valid, output action, output amount, output flag, input ready);
   modport sink   (input valid, input action, input amount, input flag, output ready);
endinterface

interface tsgc_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_pulse;
   logic        dir_level;
   logic [47:0] step_total;
   logic [31:0] position_now;
   logic [39:0] move_left;
   logic        moving;
   logic        tracking;

   modport source (output valid, output step_pulse, output dir_level, output step_total,
                   output position_now, output move_left, output moving, output tracking,
                   input ready);
   modport sink   (input valid, input step_pulse, input dir_level, input step_total,
                   input position_now, input move_left, input moving, input tracking,
                   output ready);
endinterface
`default_nettype wire

/* rtl/core/tracking_stepper_goto_controller.sv */
// Stepper controller for a tracking mount. Each request is a timer tick (sidereal or move)
// or a command (relative move, go-to, set position, start/stop tracking, stop move), and
// each request returns exactly one response with the step pulse, direction pin level,
// step counter, position, remaining move count and mode flags after that request.
// A request is latched in an input register, processed combinationally against the
// controller state, and the result lands in an output register: one request per cycle
// sustained while responses are taken, and while a response waits one more
// request is taken into the input register before the input stalls.
// csr_wr_data[0] sets the direction pin polarity (reset 1).
`default_nettype none
module tracking_stepper_goto_controller (
   input  wire logic   clock,
   input  wire logic   reset,
   tsgc_req_if.sink    req_if,
   tsgc_rsp_if.source  rsp_if,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);

   // request register
   logic                    s1_valid_ff, s1_valid_in;
   tsgc_pkg::action_type    s1_action_ff;
   logic [31:0]             s1_amount_ff;
   logic                    s1_flag_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_pulse_ff, rsp_dir_ff, rsp_moving_ff, rsp_tracking_ff;
   logic [47:0] rsp_total_ff;
   logic [31:0] rsp_pos_ff;
   logic [39:0] rsp_left_ff;

   // controller state
   logic        polarity_ff;
   logic [47:0] counter_ff, counter_in;
   logic [31:0] pos_ff, pos_in;
   logic [39:0] rem_ff, rem_in;
   logic        rev_ff, rev_in;
   logic        track_ff, track_in;
   logic        sidereal_ff, sidereal_in;
   logic        mover_ff, mover_in;
   logic        pulse;

   logic out_free, fire, req_take;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign fire         = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_take     = req_if.valid && req_if.ready;
   assign s1_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   // step datapath
   logic [47:0] step_counter;
   logic [32:0] pos_dec, pos_inc;
   logic [31:0] step_pos;
   logic [39:0] step_rem;
   logic [40:0] rem_ext;

   // command datapath
   logic [40:0] move_sum;
   logic [39:0] move_rem;
   logic [34:0] amt35, pos35, diff35, abs35, goto35;
   logic [32:0] amt33;
   logic [31:0] set_pos;

   always_comb begin
      rem_ext      = {rem_ff[39], rem_ff};
      step_counter = rev_ff ? counter_ff - 48'd1 : counter_ff + 48'd1;
      pos_dec      = {1'b0, pos_ff} - 33'd1;
      pos_inc      = {1'b0, pos_ff} + 33'd1;
      if (!rev_ff) begin
         step_pos = (pos_ff == 32'd0 || pos_dec >= tsgc_pkg::REV_STEPS)
                    ? tsgc_pkg::REV_LAST[31:0] : pos_dec[31:0];
         step_rem = tsgc_pkg::sat_rem(rem_ext - 41'd1);
      end else begin
         step_pos = (pos_inc >= tsgc_pkg::REV_STEPS)
                    ? 32'(pos_inc - tsgc_pkg::REV_STEPS) : pos_inc[31:0];
         step_rem = tsgc_pkg::sat_rem(rem_ext + 41'd1);
      end

      move_sum = rem_ext + {{9{s1_amount_ff[31]}}, s1_amount_ff};
      move_rem = tsgc_pkg::sat_rem(move_sum);

      amt35  = {{3{s1_amount_ff[31]}}, s1_amount_ff};
      pos35  = {3'b000, pos_ff};
      diff35 = pos35 - amt35;
      abs35  = diff35[34] ? 35'd0 - diff35 : diff35;
      if (abs35 > {2'b00, tsgc_pkg::REV_HALF}) begin
         goto35 = diff35[34] ? diff35 + {2'b00, tsgc_pkg::REV_STEPS}
                             : diff35 - {2'b00, tsgc_pkg::REV_STEPS};
      end else begin
         goto35 = diff35;
      end

      amt33 = {1'b0, s1_amount_ff};
      if (s1_amount_ff[31]) begin
         set_pos = 32'd0;
      end else if (amt33 > tsgc_pkg::REV_LAST) begin
         set_pos = tsgc_pkg::REV_LAST[31:0];
      end else begin
         set_pos = s1_amount_ff;
      end
   end

   always_comb begin
      counter_in  = counter_ff;
      pos_in      = pos_ff;
      rem_in      = rem_ff;
      rev_in      = rev_ff;
      track_in    = track_ff;
      sidereal_in = sidereal_ff;
      mover_in    = mover_ff;
      pulse       = 1'b0;
      unique case (s1_action_ff)
         tsgc_pkg::ACT_SIDEREAL_TICK, tsgc_pkg::ACT_MOVE_TICK: begin
            if ((s1_action_ff == tsgc_pkg::ACT_SIDEREAL_TICK) ? sidereal_ff : mover_ff) begin
               pulse      = 1'b1;
               counter_in = step_counter;
               if (rem_ff != 40'd0) begin
                  pos_in = step_pos;
                  rem_in = step_rem;
                  rev_in = step_rem[39];
                  if (step_rem == 40'd0) begin
                     mover_in = 1'b0;
                     rev_in   = 1'b0;
                     if (track_ff) begin
                        sidereal_in = 1'b1;
                     end
                  end
               end
            end
         end
         tsgc_pkg::ACT_MOVE_REL: begin
            if (s1_amount_ff != 32'd0) begin
               if (track_ff) begin
                  sidereal_in = 1'b0;
               end
               rem_in   = move_rem;
               rev_in   = move_rem[39];
               mover_in = (move_rem != 40'd0);
            end
         end
         tsgc_pkg::ACT_GOTO: begin
            if (diff35 != 35'd0) begin
               if (track_ff) begin
                  sidereal_in = 1'b0;
               end
               rem_in   = {{5{goto35[34]}}, goto35};
               rev_in   = goto35[34];
               mover_in = (goto35 != 35'd0);
            end
         end
         tsgc_pkg::ACT_SET_POS: begin
            pos_in = set_pos;
         end
         tsgc_pkg::ACT_START_TRACK: begin
            if (s1_flag_ff) begin
               counter_in = 48'd0;
            end
            track_in    = 1'b1;
            sidereal_in = 1'b1;
            rev_in      = rem_ff[39];
         end
         tsgc_pkg::ACT_STOP_TRACK: begin
            sidereal_in = 1'b0;
            if (!s1_flag_ff) begin
               track_in = 1'b0;
            end
         end
         tsgc_pkg::ACT_STOP_MOVE: begin
            mover_in = 1'b0;
            rem_in   = 40'd0;
            rev_in   = 1'b0;
            if (s1_flag_ff && track_ff) begin
               sidereal_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         polarity_ff  <= 1'b1;
         counter_ff   <= 48'd0;
         pos_ff       <= 32'd0;
         rem_ff       <= 40'd0;
         rev_ff       <= 1'b0;
         track_ff     <= 1'b0;
         sidereal_ff  <= 1'b0;
         mover_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            polarity_ff <= csr_wr_data;
         end
         if (fire) begin
            counter_ff  <= counter_in;
            pos_ff      <= pos_in;
            rem_ff      <= rem_in;
            rev_ff      <= rev_in;
            track_ff    <= track_in;
            sidereal_ff <= sidereal_in;
            mover_ff    <= mover_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= tsgc_pkg::action_type'(req_if.action);
         s1_amount_ff <= req_if.amount;
         s1_flag_ff   <= req_if.flag;
      end
      if (fire) begin
         rsp_pulse_ff    <= pulse;
         rsp_dir_ff      <= polarity_ff ^ rev_in;
         rsp_total_ff    <= counter_in;
         rsp_pos_ff      <= pos_in;
         rsp_left_ff     <= rem_in;
         rsp_moving_ff   <= mover_in;
         rsp_tracking_ff <= track_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.step_pulse   = rsp_pulse_ff;
   assign rsp_if.dir_level    = rsp_dir_ff;
   assign rsp_if.step_total   = rsp_total_ff;
   assign rsp_if.position_now = rsp_pos_ff;
   assign rsp_if.move_left    = rsp_left_ff;
   assign rsp_if.moving       = rsp_moving_ff;
   assign rsp_if.tracking     = rsp_tracking_ff;

endmodule
`default_nettype wire
